// File: design/lut_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut_pkg: shared types and constants
// Action codes, register indexes and sequencer states for the lookup table.
// ----------------------------------------------------------------------------
package lut_pkg;

	localparam logic [1:0] ACT_LOAD_X = 2'd0;
	localparam logic [1:0] ACT_LOAD_Y = 2'd1;
	localparam logic [1:0] ACT_LOAD_Z = 2'd2;
	localparam logic [1:0] ACT_QUERY  = 2'd3;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_X_COUNT = 2'd1;
	localparam logic [1:0] REG_Y_COUNT = 2'd2;

	localparam int ZDepth = 256;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_XSRCH  = 11'b00000000010,
		ST_XRD    = 11'b00000000100,
		ST_XDONE  = 11'b00000001000,
		ST_YSRCH  = 11'b00000010000,
		ST_ZRD    = 11'b00000100000,
		ST_ZWAIT  = 11'b00001000000,
		ST_MUL    = 11'b00010000000,
		ST_DIV    = 11'b00100000000,
		ST_FIN    = 11'b01000000000,
		ST_OUT    = 11'b10000000000
	} state_t;

endpackage

// File: design/lut_interpolation_1d_2d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut_interpolation_1d_2d_top: 1D/2D lookup table with linear interpolation
// Breakpoint and grid loads plus queries, one shared multiply/divide unit.
// ----------------------------------------------------------------------------
// Load requests (x, y breakpoint or z entry) give no result and leave busy
// low. A query request is worked through by the single sequencer, which
// runs up to two binary searches and up to three interpolations, each one a
// 33x33-bit multiply and a 66-bit restoring divide at one quotient bit a cycle.
// busy stays high meanwhile and no new request is taken; done is high for
// exactly one cycle with the result on result_value/config_error, and the
// receiver cannot stall it.
module lut_interpolation_1d_2d_top #(
	parameter int NX_MAX = 16,
	parameter int NY_MAX = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [7:0]         index,
	input  logic signed [31:0] load_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic               config_error
);
	localparam int XW = $clog2(NX_MAX);
	localparam int YW = $clog2(NY_MAX);

	// storage
	logic signed [31:0] xbp_mem [NX_MAX];
	logic signed [31:0] ybp_mem [NY_MAX];
	logic signed [31:0] z_mem [lut_pkg::ZDepth];

	logic       mode_q;
	logic [4:0] xcnt_q, ycnt_q;

	lut_pkg::state_t st_q;
	logic signed [31:0] qx_q, qy_q;
	// search window
	logic signed [9:0] lo_q, hi_q;
	logic [8:0] seg_q;          // found segment
	logic [8:0] iy_q;
	logic       ysel_q;         // searching y axis
	// memory read
	logic signed [31:0] bp_rd_q, z_rd_q;
	logic signed [31:0] x0_q, x1_q, y0_q, y1_q;
	logic signed [31:0] za_q, zb_q, zc0_q, zc1_q;
	logic [1:0]  step_q;        // interpolation number
	logic [1:0]  sub_q;         // read sub-step
	// arithmetic
	logic [32:0] ua_q, ub_q, ud_q;
	logic        neg_q;
	logic [65:0] prod_q, rem_q;
	logic [6:0]  bit_q;
	logic signed [31:0] res_q, base_q;
	logic        err_q;

	logic [4:0] nx, ny;
	assign nx = (int'(xcnt_q) > NX_MAX) ? 5'(NX_MAX) : xcnt_q;
	assign ny = (int'(ycnt_q) > NY_MAX) ? 5'(NY_MAX) : ycnt_q;

	assign busy = (st_q != lut_pkg::ST_IDLE);
	logic accept;
	assign accept = start && !busy;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			xcnt_q <= '0;
			ycnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lut_pkg::REG_MODE:    mode_q <= cfg_data[0];
				lut_pkg::REG_X_COUNT: xcnt_q <= cfg_data;
				lut_pkg::REG_Y_COUNT: ycnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (accept && action == lut_pkg::ACT_LOAD_X && {1'b0, index} < 9'(NX_MAX))
			xbp_mem[index[XW-1:0]] <= load_value;
		if (accept && action == lut_pkg::ACT_LOAD_Y && {1'b0, index} < 9'(NY_MAX))
			ybp_mem[index[YW-1:0]] <= load_value;
		if (accept && action == lut_pkg::ACT_LOAD_Z)
			z_mem[index] <= load_value;
	end

	// breakpoint read address: x or y memory, one port each
	logic [8:0] bp_addr;
	logic [15:0] z_addr;
	logic        z_oob_q;
	logic        z_oob;
	always_ff @(posedge clk) begin
		if (ysel_q) bp_rd_q <= ybp_mem[bp_addr[YW-1:0]];
		else        bp_rd_q <= xbp_mem[bp_addr[XW-1:0]];
		z_rd_q  <= z_mem[z_addr[7:0]];
		z_oob_q <= z_oob;
	end
	assign z_oob = (z_addr >= 16'(lut_pkg::ZDepth));

	// mid of window; search probes bp[mid] then bp[mid+1]
	logic signed [9:0] mid;
	logic signed [10:0] mid_sum;
	assign mid_sum = 11'(lo_q) + 11'(hi_q);
	assign mid = 10'(mid_sum >>> 1);

	// search sub-step: 0/2/4/6 issue bp[0]/bp[n-1]/mid/mid+1, 1/3/5/7 compare them
	logic [2:0] ss_q;
	logic signed [31:0] qsel;
	logic [4:0] nsel;
	assign qsel = ysel_q ? qy_q : qx_q;
	assign nsel = ysel_q ? ny : nx;

	// read address generation
	logic [8:0] row_sel;
	always_comb begin
		bp_addr = '0;
		row_sel = (step_q == 2'd1) ? iy_q + 9'd1 : ((step_q == 2'd0 && mode_q) ? iy_q : 9'd0);
		z_addr  = 16'(row_sel) * 16'(nx);
		case (st_q)
			lut_pkg::ST_XSRCH, lut_pkg::ST_YSRCH: begin
				case (ss_q)
					3'd0: bp_addr = 9'(lo_q);          // boundary: first
					3'd2: bp_addr = 9'(nsel - 5'd1);   // boundary: last
					3'd4: bp_addr = 9'(mid);
					3'd6: bp_addr = 9'(mid) + 9'd1;
					default: bp_addr = 9'(mid) + 9'd1;
				endcase
			end
			lut_pkg::ST_XRD: begin
				// final y step fetches y[iy], y[iy+1]; otherwise the x segment ends
				bp_addr = (step_q == 2'd2) ? iy_q : seg_q;
				if (sub_q != 2'd0) bp_addr = bp_addr + 9'd1;
			end
			default: bp_addr = '0;
		endcase
		if (st_q == lut_pkg::ST_ZRD)
			z_addr = z_addr + 16'(seg_q) + ((sub_q == 2'd0) ? 16'd0 : 16'd1);
	end

	// interpolation operands
	logic signed [32:0] a_w, b_w, d_w;
	logic signed [31:0] lx0, lx1, lz0, lz1, lq;
	always_comb begin
		if (step_q == 2'd2) begin
			lx0 = y0_q; lx1 = y1_q; lz0 = zc0_q; lz1 = zc1_q; lq = qy_q;
		end else begin
			lx0 = x0_q; lx1 = x1_q; lz0 = za_q; lz1 = zb_q; lq = qx_q;
		end
		a_w = 33'(lq) - 33'(lx0);
		b_w = 33'(lz1) - 33'(lz0);
		d_w = 33'(lx1) - 33'(lx0);
	end

	// restoring divide step
	logic [66:0] trial;
	assign trial = {rem_q, prod_q[65]} - {34'd0, ud_q};

	logic [65:0] quo;
	assign quo = prod_q;  // after 66 steps prod_q holds the quotient
	// base +/- quotient up to 2^33 needs 35 signed bits
	logic signed [34:0] sum_w;
	assign sum_w = neg_q ? 35'(base_q) - 35'(quo[33:0]) : 35'(base_q) + 35'(quo[33:0]);

	// clamp segment result
	logic signed [31:0] fin_val;
	always_comb begin
		if (quo > 66'h200000000)
			fin_val = neg_q ? 32'sh80000000 : 32'sh7fffffff;
		else if (sum_w > 35'sh7fffffff)
			fin_val = 32'sh7fffffff;
		else if (sum_w < -35'sh80000000)
			fin_val = 32'sh80000000;
		else
			fin_val = 32'(sum_w);
	end

	// query sequencer: searches, reads, multiply/divide, store each segment value and go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= lut_pkg::ST_IDLE;
			ss_q   <= '0;
			sub_q  <= '0;
			step_q <= '0;
			ysel_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				lut_pkg::ST_IDLE: begin
					if (accept && action == lut_pkg::ACT_QUERY) begin
						qx_q   <= query_x;
						qy_q   <= query_y;
						err_q  <= 1'b0;
						res_q  <= '0;
						step_q <= 2'd0;
						ss_q   <= '0;
						sub_q  <= '0;
						lo_q   <= '0;
						seg_q  <= '0;
						iy_q   <= '0;
						if (mode_q && (nx < 5'd2 || ny < 5'd2)) begin
							err_q <= 1'b1;
							st_q  <= lut_pkg::ST_OUT;
						end else if (mode_q) begin
							ysel_q <= 1'b1;
							hi_q   <= 10'(ny) - 10'sd1;
							st_q   <= lut_pkg::ST_YSRCH;
						end else if (nx == 5'd0) begin
							st_q <= lut_pkg::ST_OUT;
						end else if (nx == 5'd1) begin
							sub_q <= 2'd0;
							st_q  <= lut_pkg::ST_ZRD;
						end else begin
							ysel_q <= 1'b0;
							hi_q   <= 10'(nx) - 10'sd1;
							st_q   <= lut_pkg::ST_XSRCH;
						end
					end
				end
				lut_pkg::ST_XSRCH, lut_pkg::ST_YSRCH: begin
					ss_q <= ss_q + 3'd1;
					case (ss_q)
						3'd1: begin
							if (qsel <= bp_rd_q) begin
								seg_q <= '0;
								ss_q  <= '0;
								st_q  <= lut_pkg::ST_XDONE;
							end
						end
						3'd3: begin
							if (qsel >= bp_rd_q) begin
								seg_q <= 9'(nsel) - 9'd2;
								ss_q  <= '0;
								st_q  <= lut_pkg::ST_XDONE;
							end
						end
						3'd4: begin
							if (lo_q > hi_q || mid > 10'(nsel) - 10'sd2) begin
								seg_q <= '0;
								ss_q  <= '0;
								st_q  <= lut_pkg::ST_XDONE;
							end
						end
						3'd5: begin
							if (qsel < bp_rd_q) begin
								hi_q <= mid - 10'sd1;
								ss_q <= 3'd4;
							end
						end
						3'd7: begin
							if (qsel > bp_rd_q) begin
								lo_q <= mid + 10'sd1;
								ss_q <= 3'd4;
							end else begin
								seg_q <= 9'(mid);
								ss_q  <= '0;
								st_q  <= lut_pkg::ST_XDONE;
							end
						end
						default: ;
					endcase
				end
				lut_pkg::ST_XDONE: begin
					// a search ended; for x also mark clamp cases by seg
					if (ysel_q) begin
						iy_q   <= seg_q;
						ysel_q <= 1'b0;
						lo_q   <= '0;
						hi_q   <= 10'(nx) - 10'sd1;
						st_q   <= lut_pkg::ST_XSRCH;
					end else begin
						sub_q <= '0;
						st_q  <= lut_pkg::ST_XRD;
					end
				end
				lut_pkg::ST_XRD: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd1) x0_q <= bp_rd_q;
					if (sub_q == 2'd2) begin
						x1_q  <= bp_rd_q;
						sub_q <= '0;
						st_q  <= lut_pkg::ST_ZRD;
					end
				end
				lut_pkg::ST_ZRD: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd1) za_q <= z_oob_q ? 32'sd0 : z_rd_q;
					if (sub_q == 2'd2) begin
						zb_q  <= z_oob_q ? 32'sd0 : z_rd_q;
						sub_q <= '0;
						st_q  <= lut_pkg::ST_ZWAIT;
					end
				end
				lut_pkg::ST_ZWAIT: begin
					// resolve clamps/degenerate segment, else start lerp
					if (!mode_q && nx == 5'd1) begin
						res_q <= za_q;
						st_q  <= lut_pkg::ST_OUT;
					end else if (qx_q <= x0_q && seg_q == 9'd0) begin
						base_q <= za_q;
						st_q   <= lut_pkg::ST_FIN;
						prod_q <= '0;
						neg_q  <= 1'b0;
					end else if (qx_q >= x1_q && seg_q == 9'(nx) - 9'd2) begin
						base_q <= zb_q;
						st_q   <= lut_pkg::ST_FIN;
						prod_q <= '0;
						neg_q  <= 1'b0;
					end else if (x1_q == x0_q) begin
						base_q <= za_q;
						st_q   <= lut_pkg::ST_FIN;
						prod_q <= '0;
						neg_q  <= 1'b0;
					end else begin
						st_q <= lut_pkg::ST_MUL;
					end
				end
				lut_pkg::ST_MUL: begin
					ua_q   <= a_w[32] ? 33'(-a_w) : 33'(a_w);
					ub_q   <= b_w[32] ? 33'(-b_w) : 33'(b_w);
					ud_q   <= d_w[32] ? 33'(-d_w) : 33'(d_w);
					neg_q  <= (a_w[32] ^ b_w[32]) ^ d_w[32];
					base_q <= lz0;
					sub_q  <= sub_q + 2'd1;
					if (sub_q == 2'd1) begin
						prod_q <= 66'(ua_q) * 66'(ub_q);
						rem_q  <= '0;
						bit_q  <= 7'd66;
						sub_q  <= '0;
						st_q   <= lut_pkg::ST_DIV;
					end
				end
				lut_pkg::ST_DIV: begin
					bit_q <= bit_q - 7'd1;
					if (!trial[66]) begin
						rem_q  <= trial[65:0];
						prod_q <= {prod_q[64:0], 1'b1};
					end else begin
						rem_q  <= {rem_q[64:0], prod_q[65]};
						prod_q <= {prod_q[64:0], 1'b0};
					end
					if (bit_q == 7'd1) st_q <= lut_pkg::ST_FIN;
				end
				lut_pkg::ST_FIN: begin
					case (step_q)
						2'd0: begin
							if (mode_q) begin
								zc0_q  <= fin_val;
								step_q <= 2'd1;
								sub_q  <= '0;
								st_q   <= lut_pkg::ST_ZRD;
							end else begin
								res_q <= fin_val;
								st_q  <= lut_pkg::ST_OUT;
							end
						end
						2'd1: begin
							zc1_q  <= fin_val;
							step_q <= 2'd2;
							sub_q  <= '0;
							ysel_q <= 1'b1;
							st_q   <= lut_pkg::ST_XRD;
						end
						default: begin
							res_q <= fin_val;
							st_q  <= lut_pkg::ST_OUT;
						end
					endcase
				end
				lut_pkg::ST_OUT: begin
					done <= 1'b1;
					st_q <= lut_pkg::ST_IDLE;
				end
				default: st_q <= lut_pkg::ST_IDLE;
			endcase
			// y breakpoint fetch for the final step reuses XRD with the y memory
			if (st_q == lut_pkg::ST_XRD && step_q == 2'd2) begin
				if (sub_q == 2'd1) y0_q <= bp_rd_q;
				if (sub_q == 2'd2) begin
					y1_q   <= bp_rd_q;
					ysel_q <= 1'b0;
					st_q   <= lut_pkg::ST_YSRCH;
					ss_q   <= 3'd0;
				end
			end
			// final y step: evaluate clamps on y, then lerp
			if (st_q == lut_pkg::ST_YSRCH && step_q == 2'd2) begin
				ss_q <= '0;
				if (qy_q <= y0_q) begin
					base_q <= zc0_q; prod_q <= '0; neg_q <= 1'b0;
					st_q <= lut_pkg::ST_FIN;
				end else if (qy_q >= y1_q) begin
					base_q <= zc1_q; prod_q <= '0; neg_q <= 1'b0;
					st_q <= lut_pkg::ST_FIN;
				end else begin
					sub_q <= '0;
					st_q  <= lut_pkg::ST_MUL;
				end
			end
		end
	end

	// bp read for final y step uses iy
	// (seg_q still holds the x segment; y addresses come from iy_q)
	assign result_value = res_q;
	assign config_error = err_q;

endmodule

// File: design/lut_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut_checker: port-level checks
// Watches handshake and result ports of the lookup table top level.
// ----------------------------------------------------------------------------
module lut_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        config_error,
	input logic [31:0] result_value
);
	// a result is one cycle wide
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	// results come at the end of a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");
	// block is free after a result
	a_free_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy with done");
	// error results are zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && config_error) |-> (result_value == 32'd0))
		else $error("error result not zero");
endmodule

bind lut_interpolation_1d_2d_top lut_checker u_lut_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.config_error(config_error), .result_value(result_value)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lut_interpolation_1d_2d_top
// Directed table of loads, queries and register writes, then random phases
// over modes and breakpoint counts. Every query result is checked against an
// in-bench interpolation predictor, or against a typed value where obvious.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NBP = 16;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic [7:0]         index;
	logic signed [31:0] load_value;
	logic signed [31:0] query_x;
	logic signed [31:0] query_y;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [4:0]         cfg_data;
	logic               done;
	logic signed [31:0] result_value;
	logic               config_error;

	lut_interpolation_1d_2d_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .index(index), .load_value(load_value),
		.query_x(query_x), .query_y(query_y),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .result_value(result_value), .config_error(config_error)
	);

	// expected query result
	typedef struct {
		int value;
		bit err;
	} lut_result_t;

	typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

	// one line of the directed table; typed marks a hand-written expectation
	typedef struct {
		row_kind_t kind;
		logic [1:0] reg_idx;
		logic [4:0] reg_val;
		logic [1:0] act;
		logic [7:0] idx;
		int val;
		int qx;
		int qy;
		bit typed;
		int exp_value;
		bit exp_err;
	} stim_row_t;

	// predictor copy of the tables and registers
	longint x_bp[NBP];
	longint y_bp[NBP];
	longint z_tab[lut_pkg::ZDepth];
	bit     mdl_mode;
	int     mdl_xc;
	int     mdl_yc;

	lut_result_t pending_results[$];
	stim_row_t   directed[$];
	int          error_count;
	int          burst_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// binary search for the segment holding q; n >= 2
	function automatic int find_segment(input longint bp[NBP], input int n, input longint q);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = n - 1;
		if (q <= bp[0]) return 0;
		if (q >= bp[n-1]) return n - 2;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (mid > n - 2) break;
			if (q < bp[mid]) hi = mid - 1;
			else if (q > bp[mid+1]) lo = mid + 1;
			else return mid;
		end
		return 0;
	endfunction

	// z0 + (q-x0)*(z1-z0)/(x1-x0), quotient truncated toward zero
	function automatic longint lerp_segment(input longint q, input longint x0,
			input longint x1, input longint z0, input longint z1);
		longint a;
		longint b;
		longint d;
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] ud;
		logic [63:0] quo;
		bit neg;
		a = q - x0;
		b = z1 - z0;
		d = x1 - x0;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		ud = (d < 0) ? -d : d;
		neg = ((a < 0) != (b < 0)) != (d < 0);
		quo = (ua * ub) / ud;
		if (quo > 64'h2_0000_0000) return neg ? -64'sd2147483648 : 64'sd2147483647;
		return sat32(z0 + (neg ? -longint'(quo) : longint'(quo)));
	endfunction

	function automatic longint interp_axis(input longint bp[NBP], input longint vals[NBP],
			input int n, input longint q);
		int i;
		if (n == 0) return 0;
		if (n == 1) return vals[0];
		if (q <= bp[0]) return vals[0];
		if (q >= bp[n-1]) return vals[n-1];
		i = find_segment(bp, n, q);
		if (bp[i+1] == bp[i]) return vals[i];
		return lerp_segment(q, bp[i], bp[i+1], vals[i], vals[i+1]);
	endfunction

	function automatic void grid_row(input int r, input int nx, output longint row[NBP]);
		int addr;
		for (int c = 0; c < NBP; c++) begin
			addr = r * nx + c;
			row[c] = (c < nx && addr < lut_pkg::ZDepth) ? z_tab[addr] : 0;
		end
	endfunction

	function automatic lut_result_t predict_query(input int qx, input int qy);
		lut_result_t r;
		longint row0[NBP];
		longint row1[NBP];
		longint ybp[NBP];
		longint zc[NBP];
		int nx;
		int ny;
		int iy;
		nx = (mdl_xc > NBP) ? NBP : mdl_xc;
		ny = (mdl_yc > NBP) ? NBP : mdl_yc;
		r.value = 0;
		r.err = 1'b0;
		if (!mdl_mode) begin
			grid_row(0, nx, row0);
			r.value = int'(interp_axis(x_bp, row0, nx, qx));
		end else if (nx < 2 || ny < 2) begin
			r.err = 1'b1;
		end else begin
			iy = find_segment(y_bp, ny, qy);
			grid_row(iy, nx, row0);
			grid_row(iy + 1, nx, row1);
			ybp = '{default: 0};
			zc = '{default: 0};
			zc[0] = interp_axis(x_bp, row0, nx, qx);
			zc[1] = interp_axis(x_bp, row1, nx, qx);
			ybp[0] = y_bp[iy];
			ybp[1] = y_bp[iy+1];
			r.value = int'(interp_axis(ybp, zc, 2, qy));
		end
		return r;
	endfunction

	// result checker: done is a one-cycle strobe, no back-pressure
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", result_value));
			end else begin
				lut_result_t e;
				e = pending_results.pop_front();
				if (result_value !== e.value)
					report_mismatch($sformatf("result_value %h, expected %h",
						result_value, e.value));
				if (config_error !== e.err)
					report_mismatch($sformatf("config_error %b, expected %b",
						config_error, e.err));
			end
		end
	end

	// Register write: only with the block idle. Loads give no result, so
	// a wait after the queue drains lets a trailing load settle before the write.
	task automatic write_reg(input logic [1:0] ri, input logic [4:0] rv);
		while (pending_results.size() != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = ri;
		cfg_data = rv;
		@(negedge clk);
		cfg_we = 1'b0;
		case (ri)
			lut_pkg::REG_MODE:    mdl_mode = rv[0];
			lut_pkg::REG_X_COUNT: mdl_xc = int'(rv);
			lut_pkg::REG_Y_COUNT: mdl_yc = int'(rv);
			default: ;
		endcase
	endtask

	// Drive one request at the falling edge, hold it until busy is low;
	// busy only moves at rising edges, so the negedge value decides.
	task automatic send_request(input logic [1:0] act, input logic [7:0] idx, input int val,
			input int qx, input int qy, input bit typed, input lut_result_t typed_res);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 40)) @(negedge clk);
		end
		burst_left--;
		start = 1'b1;
		action = act;
		index = idx;
		load_value = val;
		query_x = qx;
		query_y = qy;
		while (busy) @(negedge clk);
		@(posedge clk);
		case (act)
			lut_pkg::ACT_LOAD_X: if (idx < NBP) x_bp[idx] = val;
			lut_pkg::ACT_LOAD_Y: if (idx < NBP) y_bp[idx] = val;
			lut_pkg::ACT_LOAD_Z: z_tab[idx] = val;
			lut_pkg::ACT_QUERY:
				pending_results.push_back(typed ? typed_res : predict_query(qx, qy));
			default: ;
		endcase
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic add_cfg(input logic [1:0] ri, input logic [4:0] rv);
		stim_row_t r;
		r = '{kind: ROW_CFG, reg_idx: ri, reg_val: rv, default: 0};
		directed.push_back(r);
	endtask

	task automatic add_req(input logic [1:0] act, input logic [7:0] idx, input int val,
			input int qx, input int qy, input bit typed, input int ev, input bit ee);
		stim_row_t r;
		r = '{kind: ROW_REQ, act: act, idx: idx, val: val, qx: qx, qy: qy,
			typed: typed, exp_value: ev, exp_err: ee, default: 0};
		directed.push_back(r);
	endtask

	// ascending breakpoints, some equal neighbors; sometimes scrambled
	task automatic load_axis(input logic [1:0] act);
		longint cur;
		longint stepmax;
		int v;
		lut_result_t none;
		none = '{0, 0};
		stepmax = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 32'h0003_0000)
			: $urandom_range(1, 32'h0fff_ffff);
		cur = longint'($signed($urandom)) >>> $urandom_range(1, 8);
		for (int i = 0; i < NBP; i++) begin
			if ($urandom_range(0, 9) == 0) v = $urandom;
			else v = int'(sat32(cur));
			send_request(act, 8'(i), v, $urandom, $urandom, 1'b0, none);
			if ($urandom_range(0, 7) != 0) cur += $urandom_range(0, stepmax);
		end
	endtask

	function automatic int pick_coord(input longint bp[NBP], input int n);
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return $urandom;
		if (k == 1) return (n > 0) ? int'(bp[$urandom_range(0, n - 1)]) : 0;
		if (k == 2) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		if (n < 2) return $urandom;
		return int'(bp[0] + ((bp[n-1] - bp[0]) * longint'($urandom_range(0, 1000))) / 1000);
	endfunction

	initial begin
		lut_result_t none;
		lut_result_t typed_res;
		int nx;
		int ny;
		int counts[6];
		none = '{0, 0};
		error_count = 0;
		burst_left = 0;
		start = 1'b0;
		action = lut_pkg::ACT_LOAD_X;
		index = '0;
		load_value = '0;
		query_x = '0;
		query_y = '0;
		cfg_we = 1'b0;
		cfg_index = lut_pkg::REG_MODE;
		cfg_data = '0;
		x_bp = '{default: 0};
		y_bp = '{default: 0};
		z_tab = '{default: 0};
		mdl_mode = 1'b0;
		mdl_xc = 0;
		mdl_yc = 0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: empty tables, error path, count 1, clamping, ignored writes
		add_cfg(lut_pkg::REG_MODE, 0);
		add_cfg(lut_pkg::REG_X_COUNT, 0);
		add_cfg(lut_pkg::REG_Y_COUNT, 0);
		add_req(lut_pkg::ACT_QUERY, 0, 0, 32'sh12345678, 0, 1'b1, 0, 1'b0);
		add_cfg(lut_pkg::REG_MODE, 1);
		add_req(lut_pkg::ACT_QUERY, 0, 0, 0, 0, 1'b1, 0, 1'b1);
		add_cfg(2'd3, 5'd31);
		add_req(lut_pkg::ACT_LOAD_X, 0, 0, 0, 0, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_LOAD_X, 1, 32'sh0001_0000, 0, 0, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_LOAD_X, 255, 7, 0, 0, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_LOAD_Y, 0, 32'sh8000_0000, 0, 0, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_LOAD_Y, 1, 32'sh7fff_ffff, 0, 0, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_LOAD_Y, 200, 3, 0, 0, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_LOAD_Z, 0, 100, 0, 0, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_LOAD_Z, 1, 32'sh7fff_ffff, 0, 0, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_LOAD_Z, 2, 32'sh8000_0000, 0, 0, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_LOAD_Z, 3, -5, 0, 0, 1'b0, 0, 0);
		add_cfg(lut_pkg::REG_X_COUNT, 1);
		add_req(lut_pkg::ACT_QUERY, 0, 0, 32'sh7fff_ffff, 0, 1'b1, 0, 1'b1);
		add_cfg(lut_pkg::REG_MODE, 0);
		add_req(lut_pkg::ACT_QUERY, 0, 0, 32'sh7fff_ffff, 0, 1'b1, 100, 1'b0);
		add_cfg(lut_pkg::REG_X_COUNT, 2);
		add_req(lut_pkg::ACT_QUERY, 0, 0, 32'sh8000_0000, 0, 1'b1, 100, 1'b0);
		add_req(lut_pkg::ACT_QUERY, 0, 0, 32'sh7fff_ffff, 0, 1'b1, 32'sh7fff_ffff, 1'b0);
		add_req(lut_pkg::ACT_QUERY, 0, 0, 32'sh0000_8000, 0, 1'b0, 0, 0);
		add_cfg(lut_pkg::REG_MODE, 1);
		add_cfg(lut_pkg::REG_Y_COUNT, 2);
		add_req(lut_pkg::ACT_QUERY, 0, 0, 32'sh0000_4000, 32'sh0000_0000, 1'b0, 0, 0);
		add_req(lut_pkg::ACT_QUERY, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 0, 0);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				write_reg(directed[i].reg_idx, directed[i].reg_val);
			end else begin
				typed_res = '{directed[i].exp_value, directed[i].exp_err};
				send_request(directed[i].act, directed[i].idx, directed[i].val,
					directed[i].qx, directed[i].qy, directed[i].typed, typed_res);
			end
		end

		// fill every store once so no later query reads an unwritten entry
		for (int i = 0; i < NBP; i++) begin
			send_request(lut_pkg::ACT_LOAD_X, 8'(i), $urandom, 0, 0, 1'b0, none);
			send_request(lut_pkg::ACT_LOAD_Y, 8'(i), $urandom, 0, 0, 1'b0, none);
		end
		for (int i = 0; i < lut_pkg::ZDepth; i++)
			send_request(lut_pkg::ACT_LOAD_Z, 8'(i), $urandom, 0, 0, 1'b0, none);

		// random phases: register settings change only between phases
		counts = '{0, 1, 2, 16, 31, 0};
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(lut_pkg::REG_MODE, (ph % 3 == 0) ? 5'd0 : 5'd1);
			counts[5] = $urandom_range(2, 16);
			write_reg(lut_pkg::REG_X_COUNT,
				5'((ph < 5) ? counts[ph] : counts[$urandom_range(2, 5)]));
			write_reg(lut_pkg::REG_Y_COUNT,
				5'((ph < 5) ? counts[4 - ph] : counts[$urandom_range(2, 5)]));
			nx = (mdl_xc > NBP) ? NBP : mdl_xc;
			ny = (mdl_yc > NBP) ? NBP : mdl_yc;
			load_axis(lut_pkg::ACT_LOAD_X);
			load_axis(lut_pkg::ACT_LOAD_Y);
			for (int i = 0; i < nx * (mdl_mode ? ny : 1); i++)
				send_request(lut_pkg::ACT_LOAD_Z, 8'(i),
					$urandom_range(0, 3) ? int'($signed($urandom) >>> 8) : int'($urandom),
					0, 0, 1'b0, none);
			for (int k = 0; k < 60; k++) begin
				if ($urandom_range(0, 14) == 0)
					send_request(2'($urandom_range(0, 2)), 8'($urandom), $urandom,
						$urandom, $urandom, 1'b0, none);
				else
					send_request(lut_pkg::ACT_QUERY, 8'($urandom), $urandom,
						pick_coord(x_bp, nx), pick_coord(y_bp, ny), 1'b0, none);
			end
			// drain completely once per phase before the next register write
			while (pending_results.size() != 0) @(negedge clk);
		end

		while (pending_results.size() != 0) @(negedge clk);
		repeat (300) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
